// ----- hw/rtl/ifsc_pkg.sv -----
// shared types, constants and rounding helper for the imu fifo sample converter
package ifsc_pkg;

    localparam logic [3:0] LAST_POS = 4'd11;

    // configuration register indexes
    localparam logic [3:0] CFG_ACCEL_SCALE = 4'd0;
    localparam logic [3:0] CFG_GYRO_SCALE  = 4'd1;
    localparam logic [3:0] CFG_GYRO_BIAS_X = 4'd2;
    localparam logic [3:0] CFG_GYRO_BIAS_Y = 4'd3;
    localparam logic [3:0] CFG_GYRO_BIAS_Z = 4'd4;
    localparam logic [3:0] CFG_TILT_CROSS  = 4'd5;
    localparam logic [3:0] CFG_TILT_DIRECT = 4'd6;
    localparam logic [3:0] CFG_TILT_ENABLE = 4'd7;

    // operations of the shared multiplier, one per step
    localparam logic [3:0] OP_ACCEL_X  = 4'd0;
    localparam logic [3:0] OP_ACCEL_Y  = 4'd1;
    localparam logic [3:0] OP_ACCEL_Z  = 4'd2;
    localparam logic [3:0] OP_RATE_X   = 4'd3;
    localparam logic [3:0] OP_RATE_Y   = 4'd4;
    localparam logic [3:0] OP_RATE_Z   = 4'd5;
    localparam logic [3:0] OP_YAW_CROSS  = 4'd6;
    localparam logic [3:0] OP_YAW_DIRECT = 4'd7;

    localparam logic signed [59:0] SAT_MAX = 60'sd2147483647;
    localparam logic signed [59:0] SAT_MIN = -60'sd2147483648;

    typedef logic [15:0] raw_t;
    typedef raw_t [5:0] sample_t;

    typedef struct packed {
        logic        push;
        sample_t     sample;
    } smp_push_t;

    typedef struct packed {
        logic        [31:0] accel_scale;
        logic        [31:0] gyro_scale;
        logic signed [23:0] gyro_bias_x;
        logic signed [23:0] gyro_bias_y;
        logic signed [23:0] gyro_bias_z;
        logic signed [23:0] tilt_cross_coef;
        logic signed [23:0] tilt_direct_coef;
        logic               tilt_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_RUN,
        ENG_DONE
    } eng_state_t;

    // round half up, shift right by 16 or 8, saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [58:0] x,
                                                     input logic wide_shift);
        logic signed [59:0] y;
        logic signed [59:0] s;
        y = {x[58], x} + (wide_shift ? 60'sd32768 : 60'sd128);
        s = wide_shift ? (y >>> 16) : (y >>> 8);
        if (s > SAT_MAX)
            return 32'sh7fffffff;
        else if (s < SAT_MIN)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

endpackage

// ----- hw/rtl/ifsc_framer.sv -----
// byte framer: collects twelve fifo bytes into one sample of six raw values
module ifsc_framer
    import ifsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] fifo_byte,
    input  logic       burst_start,
    input  logic       q_full,
    output smp_push_t  push
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [3:0] pos_eff;
    logic       is_last;
    logic       accept;
    logic [7:0] bytes_reg [0:10];

    assign pos_eff    = burst_start ? 4'd0 : pos_reg;
    assign is_last    = (pos_eff == LAST_POS);
    // only the closing byte needs room in the queue
    assign byte_stall = q_full & is_last;
    assign accept     = byte_valid & ~byte_stall;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = is_last ? 4'd0 : pos_eff + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_last)
        begin
            bytes_reg[pos_eff] <= fifo_byte;
        end
    end

    // big-endian pairs, the last low byte comes straight from the port
    genvar i;
    generate
        for (i = 0; i < 5; i++)
        begin : g_axis
            assign push.sample[i] = {bytes_reg[2*i], bytes_reg[2*i+1]};
        end
    endgenerate
    assign push.sample[5] = {bytes_reg[10], fifo_byte};
    assign push.push      = accept & is_last;

endmodule

// ----- hw/rtl/ifsc_queue.sv -----
// two-entry sample queue between the framer and the arithmetic engine
module ifsc_queue
    import ifsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  smp_push_t push,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output sample_t   head
);

    sample_t    mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push.push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.sample;
        end
    end

endmodule

// ----- hw/rtl/ifsc_engine.sv -----
// arithmetic engine: one shared multiplier stepped over the six axes and the yaw terms
module ifsc_engine
    import ifsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  sample_t            q_head,
    output logic               q_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic signed [31:0] rate_x,
    output logic signed [31:0] rate_y,
    output logic signed [31:0] yaw_rate
);

    eng_state_t         state_reg;
    eng_state_t         state_next;
    logic [3:0]         step_reg;
    logic [3:0]         step_next;
    logic signed [57:0] prod_reg;
    logic signed [57:0] prod_next;
    logic signed [57:0] acc_reg;
    logic signed [31:0] res_reg [0:5];
    logic signed [31:0] out_reg [0:5];
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               out_free;
    logic               load;
    logic               post_en;
    logic [3:0]         post_op;
    logic signed [31:0] post_val;
    logic signed [58:0] yaw_sum;
    logic signed [31:0] yaw_val;
    logic signed [32:0] op_a;
    logic signed [24:0] op_b;
    logic signed [15:0] raw_sel;
    logic signed [23:0] bias_sel;

    assign out_free = ~out_valid_reg | ~result_stall;
    assign load     = (state_reg == ENG_DONE) & out_free;
    assign q_pop    = load;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ENG_RUN;
                    step_next  = OP_ACCEL_X;
                end
            end
            ENG_RUN:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == OP_YAW_DIRECT)
                begin
                    state_next = ENG_DONE;
                end
            end
            ENG_DONE:
            begin
                if (out_free)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // operand selection for the current step
    always_comb
    begin
        raw_sel = $signed(q_head[step_reg[2:0]]);
        unique case (step_reg)
            OP_RATE_X: bias_sel = cfg.gyro_bias_x;
            OP_RATE_Y: bias_sel = cfg.gyro_bias_y;
            default:   bias_sel = cfg.gyro_bias_z;
        endcase
        unique case (step_reg)
            OP_ACCEL_X, OP_ACCEL_Y, OP_ACCEL_Z:
            begin
                op_a = $signed({1'b0, cfg.accel_scale});
                op_b = {{9{raw_sel[15]}}, raw_sel};
            end
            OP_RATE_X, OP_RATE_Y, OP_RATE_Z:
            begin
                op_a = $signed({1'b0, cfg.gyro_scale});
                op_b = $signed({raw_sel[15], raw_sel, 8'h00}) - {bias_sel[23], bias_sel};
            end
            OP_YAW_CROSS:
            begin
                op_a = {res_reg[4][31], res_reg[4]};
                op_b = {cfg.tilt_cross_coef[23], cfg.tilt_cross_coef};
            end
            OP_YAW_DIRECT:
            begin
                op_a = {res_reg[5][31], res_reg[5]};
                op_b = {cfg.tilt_direct_coef[23], cfg.tilt_direct_coef};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = (state_reg == ENG_RUN) ? op_a * op_b : prod_reg;
    end

    // the previous step's product is rounded now; the yaw products stay whole
    assign post_en  = (state_reg == ENG_RUN) && (step_reg != OP_ACCEL_X);
    assign post_op  = step_reg - 4'd1;
    assign post_val = round_sat({prod_reg[57], prod_reg}, post_op >= OP_RATE_X);
    assign yaw_sum  = {acc_reg[57], acc_reg} + {prod_reg[57], prod_reg};
    assign yaw_val  = cfg.tilt_enable ? round_sat(yaw_sum, 1'b1) : res_reg[5];

    always_comb
    begin
        out_valid_next = out_valid_reg & result_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (post_en)
        begin
            if (post_op == OP_YAW_CROSS)
            begin
                acc_reg <= prod_reg;
            end
            else
            begin
                res_reg[post_op[2:0]] <= post_val;
            end
        end
        if (load)
        begin
            out_reg[0] <= res_reg[0];
            out_reg[1] <= res_reg[1];
            out_reg[2] <= res_reg[2];
            out_reg[3] <= res_reg[3];
            out_reg[4] <= res_reg[4];
            out_reg[5] <= yaw_val;
        end
    end

    assign result_valid = out_valid_reg;
    assign accel_x      = out_reg[0];
    assign accel_y      = out_reg[1];
    assign accel_z      = out_reg[2];
    assign rate_x       = out_reg[3];
    assign rate_y       = out_reg[4];
    assign yaw_rate     = out_reg[5];

endmodule

// ----- hw/rtl/imu_fifo_sample_converter_core.sv -----
// top level of the imu fifo sample converter: config registers, framer, queue, engine
// takes one fifo byte per cycle while byte_stall is low; every twelfth byte of a frame
// completes a sample, which passes from the queue through the engine's idle, run and done
// states into the output registers; the engine steps each sample over one shared
// multiplier, keeping up with one byte per cycle; the two-entry queue absorbs output stalls
// reset: asynchronous, clears framing, queue and output valid; config takes its reset values
module imu_fifo_sample_converter_core
    import ifsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         fifo_byte,
    input  logic               burst_start,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic signed [31:0] rate_x,
    output logic signed [31:0] rate_y,
    output logic signed [31:0] yaw_rate,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    smp_push_t push;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    sample_t   q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEL_SCALE: cfg_next.accel_scale      = cfg_data;
                CFG_GYRO_SCALE:  cfg_next.gyro_scale       = cfg_data;
                CFG_GYRO_BIAS_X: cfg_next.gyro_bias_x      = cfg_data[23:0];
                CFG_GYRO_BIAS_Y: cfg_next.gyro_bias_y      = cfg_data[23:0];
                CFG_GYRO_BIAS_Z: cfg_next.gyro_bias_z      = cfg_data[23:0];
                CFG_TILT_CROSS:  cfg_next.tilt_cross_coef  = cfg_data[23:0];
                CFG_TILT_DIRECT: cfg_next.tilt_direct_coef = cfg_data[23:0];
                CFG_TILT_ENABLE: cfg_next.tilt_enable      = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_scale      <= 32'd0;
            cfg_reg.gyro_scale       <= 32'd0;
            cfg_reg.gyro_bias_x      <= 24'sd0;
            cfg_reg.gyro_bias_y      <= 24'sd0;
            cfg_reg.gyro_bias_z      <= 24'sd0;
            cfg_reg.tilt_cross_coef  <= 24'sd0;
            cfg_reg.tilt_direct_coef <= 24'sd65536;
            cfg_reg.tilt_enable      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ifsc_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .fifo_byte   (fifo_byte),
        .burst_start (burst_start),
        .q_full      (q_full),
        .push        (push)
    );

    ifsc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    ifsc_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .rate_x       (rate_x),
        .rate_y       (rate_y),
        .yaw_rate     (yaw_rate)
    );

endmodule

// ----- hw/rtl/ifsc_checker.sv -----
// port-level checks for the imu fifo sample converter and their bind
module ifsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_stall,
    input logic        burst_start,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] accel_x,
    input logic [31:0] accel_y,
    input logic [31:0] accel_z,
    input logic [31:0] rate_x,
    input logic [31:0] rate_y,
    input logic [31:0] yaw_rate
);

    // nothing pending and nothing held off once reset has taken hold
    ap_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid && !byte_stall)
        else $error("output valid or input stall during reset");

    // the first byte of a burst never completes a sample, so it is never held off
    ap_burst_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        burst_start |-> !byte_stall)
        else $error("burst start byte stalled");

    ap_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    ap_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(accel_x) && $stable(accel_y) &&
            $stable(accel_z) && $stable(rate_x) && $stable(rate_y) && $stable(yaw_rate))
        else $error("result changed while stalled");

endmodule

bind imu_fifo_sample_converter_core ifsc_checker u_ifsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .burst_start  (burst_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .rate_x       (rate_x),
    .rate_y       (rate_y),
    .yaw_rate     (yaw_rate)
);

// ----- tb/imu_fifo_sample_converter_core_test.sv -----
// self-checking testbench for the imu fifo sample converter core with its own sample predictor
`timescale 1ns / 1ps

module imu_fifo_sample_converter_core_test;
    import ifsc_pkg::*;

    localparam int FRAME_BYTES   = 12;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_BYTES   = 125;
    localparam int PHASES        = 8;

    typedef enum {SET_NOMINAL, SET_MAX, SET_MIN, SET_WILD} setting_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } fifo_item_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] yaw_rate;
    } imu_sample_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    logic [7:0]         fifo_byte = 8'h00;
    logic               burst_start = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] yaw_rate;
    logic               cfg_we = 1'b0;
    logic [3:0]         cfg_index = 4'h0;
    logic [31:0]        cfg_data = 32'h0;

    imu_fifo_sample_converter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .fifo_byte    (fifo_byte),
        .burst_start  (burst_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .rate_x       (rate_x),
        .rate_y       (rate_y),
        .yaw_rate     (yaw_rate),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // register mirror
    logic [31:0]        accel_scale_r = 32'h0;
    logic [31:0]        gyro_scale_r = 32'h0;
    logic signed [23:0] bias_x_r = 24'sd0;
    logic signed [23:0] bias_y_r = 24'sd0;
    logic signed [23:0] bias_z_r = 24'sd0;
    logic signed [23:0] cross_coef_r = 24'sd0;
    logic signed [23:0] direct_coef_r = 24'sd65536;
    logic               tilt_en_r = 1'b0;

    // framer mirror
    int         frame_pos = 0;
    logic [7:0] frame_bytes [0:FRAME_BYTES-1];

    fifo_item_t  byte_backlog [$];
    imu_sample_t expected_samples [$];

    int mismatches = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_mode_left = 0;
    int burst_left = 0;
    int gap_left = 0;
    int quiet_cycles = 0;
    bit offer_next;
    bit stall_next;
    bit gen_misaligned = 1'b0;

    function automatic longint round_half_up(input longint x, input int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_q16(input longint x);
        if (x > longint'(2147483647))
            return longint'(2147483647);
        else if (x < longint'(-2147483647) - 1)
            return longint'(-2147483647) - 1;
        return x;
    endfunction

    function automatic longint gyro_rate(input longint raw, input logic signed [23:0] bias);
        longint diff;
        diff = raw * 256 - longint'(bias);
        return clamp_q16(round_half_up(diff * longint'({32'd0, gyro_scale_r}), 16));
    endfunction

    // one accepted fifo byte; the twelfth of a frame yields one sample
    task automatic take_fifo_byte(input logic [7:0] data, input logic start);
        longint      raw [6];
        longint      ry;
        longint      rz;
        imu_sample_t s;
        if (start)
            frame_pos = 0;
        if (frame_pos >= FRAME_BYTES)
            frame_pos = 0;
        frame_bytes[frame_pos] = data;
        if (frame_pos < FRAME_BYTES - 1)
        begin
            frame_pos++;
        end
        else
        begin
            frame_pos = 0;
            for (int i = 0; i < 6; i++)
                raw[i] = longint'($signed({frame_bytes[2 * i], frame_bytes[2 * i + 1]}));
            s.accel_x = 32'(clamp_q16(round_half_up(raw[0] * longint'({32'd0, accel_scale_r}), 8)));
            s.accel_y = 32'(clamp_q16(round_half_up(raw[1] * longint'({32'd0, accel_scale_r}), 8)));
            s.accel_z = 32'(clamp_q16(round_half_up(raw[2] * longint'({32'd0, accel_scale_r}), 8)));
            s.rate_x = 32'(gyro_rate(raw[3], bias_x_r));
            ry = gyro_rate(raw[4], bias_y_r);
            rz = gyro_rate(raw[5], bias_z_r);
            s.rate_y = 32'(ry);
            // yaw mixes the already saturated rates
            if (tilt_en_r)
                s.yaw_rate = 32'(clamp_q16(round_half_up(ry * longint'(cross_coef_r)
                                                         + rz * longint'(direct_coef_r), 16)));
            else
                s.yaw_rate = 32'(rz);
            expected_samples.push_back(s);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sender: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            offer_next = byte_valid;
            if (byte_valid && !byte_stall)
            begin
                take_fifo_byte(fifo_byte, burst_start);
                void'(byte_backlog.pop_front());
                offer_next = 1'b0;
            end
            if (!offer_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (byte_backlog.size() > 0)
                begin
                    offer_next = 1'b1;
                    fifo_byte <= byte_backlog[0].data;
                    burst_start <= byte_backlog[0].start;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            byte_valid <= offer_next;
        end
    end

    // receiver: checks each sample and stalls on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("sample with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    check_field("accel_x", expected_samples[0].accel_x, accel_x);
                    check_field("accel_y", expected_samples[0].accel_y, accel_y);
                    check_field("accel_z", expected_samples[0].accel_z, accel_z);
                    check_field("rate_x", expected_samples[0].rate_x, rate_x);
                    check_field("rate_y", expected_samples[0].rate_y, rate_y);
                    check_field("yaw_rate", expected_samples[0].yaw_rate, yaw_rate);
                    void'(expected_samples.pop_front());
                end
            end
            if (hold_served != hold_asked)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if (stall_mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    stall_mode_left = $urandom_range(16, 96);
                end
                stall_mode_left--;
                case (stall_mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 3) == 0);
                    2: stall_next = ($urandom_range(0, 3) != 0);
                    default: stall_next = ~result_stall;
                endcase
            end
            result_stall <= stall_next;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[imu_fifo_sample_converter_core] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_ACCEL_SCALE: accel_scale_r = data;
            CFG_GYRO_SCALE:  gyro_scale_r = data;
            CFG_GYRO_BIAS_X: bias_x_r = data[23:0];
            CFG_GYRO_BIAS_Y: bias_y_r = data[23:0];
            CFG_GYRO_BIAS_Z: bias_z_r = data[23:0];
            CFG_TILT_CROSS:  cross_coef_r = data[23:0];
            CFG_TILT_DIRECT: direct_coef_r = data[23:0];
            CFG_TILT_ENABLE: tilt_en_r = data[0];
            default: ;
        endcase
    endtask

    // upper bits of narrow registers carry junk, and one write goes to an unused index
    task automatic load_config(input setting_t kind, input int phase);
        logic [31:0] a;
        logic [31:0] g;
        logic [23:0] bx;
        logic [23:0] by;
        logic [23:0] bz;
        logic [23:0] cc;
        logic [23:0] dc;
        logic        en;
        case (kind)
            SET_NOMINAL:
            begin
                a = $urandom_range(0, 1 << 22);
                g = $urandom_range(0, 1 << 22);
                bx = 24'(int'($urandom_range(0, 8192)) - 4096);
                by = 24'(int'($urandom_range(0, 8192)) - 4096);
                bz = 24'(int'($urandom_range(0, 8192)) - 4096);
                cc = 24'(int'($urandom_range(0, 131072)) - 65536);
                dc = 24'(int'($urandom_range(0, 65536)) + 32768);
                en = phase[0];
            end
            SET_MAX:
            begin
                a = 32'hffff_ffff;
                g = 32'hffff_ffff;
                bx = 24'h7f_ffff;
                by = 24'h7f_ffff;
                bz = 24'h7f_ffff;
                cc = 24'h7f_ffff;
                dc = 24'h7f_ffff;
                en = 1'b1;
            end
            SET_MIN:
            begin
                a = 32'h0;
                g = 32'hffff_ffff;
                bx = 24'h80_0000;
                by = 24'h80_0000;
                bz = 24'h80_0000;
                cc = 24'h80_0000;
                dc = 24'h80_0000;
                en = 1'b1;
            end
            default:
            begin
                a = $urandom;
                g = $urandom;
                bx = 24'($urandom);
                by = 24'($urandom);
                bz = 24'($urandom);
                cc = 24'($urandom);
                dc = 24'($urandom);
                en = 1'($urandom);
            end
        endcase
        write_reg(CFG_ACCEL_SCALE, a);
        write_reg(CFG_GYRO_SCALE, g);
        write_reg(CFG_GYRO_BIAS_X, {8'($urandom), bx});
        write_reg(CFG_GYRO_BIAS_Y, {8'($urandom), by});
        write_reg(CFG_GYRO_BIAS_Z, {8'($urandom), bz});
        write_reg(CFG_TILT_CROSS, {8'($urandom), cc});
        write_reg(CFG_TILT_DIRECT, {8'($urandom), dc});
        write_reg(CFG_TILT_ENABLE, {31'($urandom), en});
        write_reg(CFG_TILT_ENABLE + 4'($urandom_range(1, 8)), $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] data, input logic start);
        fifo_item_t it;
        it.data = data;
        it.start = start;
        byte_backlog.push_back(it);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic start);
        logic [15:0] raw;
        for (int i = 0; i < 6; i++)
        begin
            raw = pick_raw();
            push_byte(raw[15:8], start && (i == 0));
            push_byte(raw[7:0], 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (byte_backlog.size() != 0 || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          len;
        setting_t    kind;
        logic [15:0] words [6];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturating settings, a partial frame dropped by a burst start
        // arriving at the last byte position, then a frame of extreme values
        load_config(SET_MAX, 0);
        words = '{16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'hffff};
        for (int i = 0; i < 11; i++)
            push_byte((i % 2) ? words[i / 2][7:0] : words[i / 2][15:8], i == 0);
        for (int i = 0; i < 12; i++)
            push_byte((i % 2) ? words[i / 2][7:0] : words[i / 2][15:8], i == 0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1, 6: kind = SET_WILD;
                2: kind = SET_MIN;
                4: kind = SET_MAX;
                default: kind = SET_NOMINAL;
            endcase
            load_config(kind, phase);
            // long output hold-off so the input side backs up
            if (phase == 3)
                hold_asked++;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    push_sample(gen_misaligned || $urandom_range(0, 1));
                    gen_misaligned = 1'b0;
                    sent += FRAME_BYTES;
                end
                else if ($urandom_range(0, 1))
                begin
                    len = $urandom_range(1, FRAME_BYTES - 1);
                    for (int i = 0; i < len; i++)
                        push_byte(8'($urandom), i == 0);
                    gen_misaligned = 1'b1;
                    sent += len;
                end
                else
                begin
                    push_byte(8'($urandom), 1'($urandom));
                    gen_misaligned = 1'b1;
                    sent++;
                end
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("[imu_fifo_sample_converter_core] OK");
        else
            $display("[imu_fifo_sample_converter_core] ERROR");
        $finish;
    end

endmodule
